### src/itp_pkg.sv
// shared constants, types and helpers for the infix to postfix converter
package itp_pkg;

   // sizing
   localparam int STACK_DEPTH = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int ENTRY_W     = 3;
   localparam int KIND_W      = 3;
   localparam int OKIND_W     = 2;

   // stream widths, fields packed from bit 0 and padded to whole bytes
   localparam int REQ_FIELDS_W = VALUE_WIDTH + ENTRY_W;
   localparam int RSP_FIELDS_W = VALUE_WIDTH + ENTRY_W + 1;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // input token kinds
   localparam logic [KIND_W-1:0] KIND_OPERAND  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_OPERATOR = 3'd1;
   localparam logic [KIND_W-1:0] KIND_OPEN     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLOSE    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_END      = 3'd4;

   // result kinds
   localparam logic [OKIND_W-1:0] OUT_OPERAND  = 2'd0;
   localparam logic [OKIND_W-1:0] OUT_OPERATOR = 2'd1;
   localparam logic [OKIND_W-1:0] OUT_END      = 2'd2;

   // operator codes and the stack mark for an opening brace
   localparam logic [ENTRY_W-1:0] OP_PLUS    = 3'd0;
   localparam logic [ENTRY_W-1:0] OP_MINUS   = 3'd1;
   localparam logic [ENTRY_W-1:0] OP_MUL     = 3'd2;
   localparam logic [ENTRY_W-1:0] OP_DIV     = 3'd3;
   localparam logic [ENTRY_W-1:0] OP_POW     = 3'd4;
   localparam logic [ENTRY_W-1:0] OP_MOD     = 3'd5;
   localparam logic [ENTRY_W-1:0] BRACE_MARK = 3'd6;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MARK
   } state_type;

   // one result beat
   typedef struct packed {
      logic [OKIND_W-1:0]            kind;
      logic signed [VALUE_WIDTH-1:0] value;
      logic [ENTRY_W-1:0]            oper;
      logic                          overflow;
      logic                          last;
   } beat_type;

   // stack memory request from the sequencer
   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [ENTRY_W-1:0] wr_data;
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
   } stack_req_type;

   // binding strength: + - low, * / % middle, ^ high
   function automatic logic [1:0] op_rank(input logic [ENTRY_W-1:0] op);
      logic [1:0] rank;
      case (op)
         OP_PLUS, OP_MINUS: rank = 2'd1;
         OP_POW:            rank = 2'd3;
         default:           rank = 2'd2;
      endcase
      return rank;
   endfunction

endpackage

### src/itp_stack_ram.sv
// operator stack storage: one write port, one registered read port
module itp_stack_ram #(
   parameter int DEPTH  = 32,
   parameter int WIDTH  = 3,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/itp_out_fifo.sv
// two-entry result buffer between the sequencer and the rsp stream
module itp_out_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   input  itp_pkg::beat_type wr_beat,
   output logic              has_space,
   output logic              rd_valid,
   input  logic              rd_ready,
   output itp_pkg::beat_type rd_beat
);
   import itp_pkg::*;

   beat_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   assign has_space = (count_ff != 2'd2);
   assign rd_valid  = (count_ff != 2'd0);
   assign rd_beat   = slot_ff[rd_ptr_ff];
   assign do_wr     = wr_valid && has_space;
   assign do_rd     = rd_valid && rd_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_beat;
      end
   end

endmodule

### src/itp_ctrl.sv
// token sequencer: reads, pops and pushes the operator stack memory
module itp_ctrl (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   tok_valid,
   output logic                                   tok_ready,
   input  logic [itp_pkg::KIND_W-1:0]             tok_kind,
   input  logic signed [itp_pkg::VALUE_WIDTH-1:0] tok_value,
   input  logic [itp_pkg::ENTRY_W-1:0]            tok_oper,
   output logic                                   beat_valid,
   output itp_pkg::beat_type                      beat,
   input  logic                                   beat_space,
   output itp_pkg::stack_req_type                 stack_req,
   input  logic [itp_pkg::ENTRY_W-1:0]            stack_top
);
   import itp_pkg::*;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               ovf_ff, ovf_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [ENTRY_W-1:0] op_ff, op_in;
   logic               pend_ff, pend_in;
   logic [ENTRY_W-1:0] pend_op_ff, pend_op_in;

   logic [COUNT_W-1:0] cnt_m1, cnt_m2;
   logic               stack_full, stop, drop_brace, can_emit;

   assign cnt_m1     = cnt_ff - COUNT_W'(1);
   assign cnt_m2     = cnt_ff - COUNT_W'(2);
   assign stack_full = (cnt_ff == COUNT_W'(STACK_DEPTH));
   assign can_emit   = !pend_ff || beat_space;

   // stop condition on the entry just read from the top of stack
   always_comb begin
      stop       = (cnt_ff == '0);
      drop_brace = 1'b0;
      if (cnt_ff != '0) begin
         unique case (kind_ff) inside
            KIND_OPERATOR: begin
               stop = (stack_top == BRACE_MARK) || (op_rank(stack_top) < op_rank(op_ff));
            end
            KIND_CLOSE: begin
               stop = (stack_top == BRACE_MARK);
            end
            default: begin
               drop_brace = (stack_top == BRACE_MARK);
            end
         endcase
      end
   end

   // next state and outputs
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      ovf_in     = ovf_ff;
      kind_in    = kind_ff;
      op_in      = op_ff;
      pend_in    = pend_ff;
      pend_op_in = pend_op_ff;
      tok_ready  = 1'b0;
      beat_valid = 1'b0;
      beat       = '0;
      stack_req  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            tok_ready = beat_space;
            if (tok_valid && beat_space) begin
               kind_in = tok_kind;
               op_in   = tok_oper;
               unique case (tok_kind) inside
                  KIND_OPERAND: begin
                     beat_valid = 1'b1;
                     beat.kind  = OUT_OPERAND;
                     beat.value = tok_value;
                     beat.last  = 1'b1;
                  end
                  KIND_OPERATOR, KIND_CLOSE, KIND_END: begin
                     // operator codes past modulo are ignored
                     if (tok_kind != KIND_OPERATOR || tok_oper <= OP_MOD) begin
                        state_in          = ST_CHECK;
                        stack_req.rd_en   = (cnt_ff != '0);
                        stack_req.rd_addr = cnt_m1[ADDR_W-1:0];
                     end
                  end
                  KIND_OPEN: begin
                     if (stack_full) begin
                        ovf_in = 1'b1;
                     end else begin
                        stack_req.wr_en   = 1'b1;
                        stack_req.wr_addr = cnt_ff[ADDR_W-1:0];
                        stack_req.wr_data = BRACE_MARK;
                        cnt_in            = cnt_ff + COUNT_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_CHECK: begin
            if (!stop && drop_brace) begin
               // unclosed brace at end of expression
               cnt_in            = cnt_m1;
               stack_req.rd_en   = (cnt_ff > COUNT_W'(1));
               stack_req.rd_addr = cnt_m2[ADDR_W-1:0];
            end else if (!stop) begin
               // pop one operator, held back one beat to know the last one
               if (can_emit) begin
                  beat_valid        = pend_ff;
                  beat.kind         = OUT_OPERATOR;
                  beat.oper         = pend_op_ff;
                  pend_in           = 1'b1;
                  pend_op_in        = stack_top;
                  cnt_in            = cnt_m1;
                  stack_req.rd_en   = (cnt_ff > COUNT_W'(1));
                  stack_req.rd_addr = cnt_m2[ADDR_W-1:0];
               end
            end else if (can_emit) begin
               beat_valid = pend_ff;
               beat.kind  = OUT_OPERATOR;
               beat.oper  = pend_op_ff;
               beat.last  = (kind_ff != KIND_END);
               pend_in    = 1'b0;
               state_in   = ST_IDLE;
               unique case (kind_ff) inside
                  KIND_OPERATOR: begin
                     if (stack_full) begin
                        ovf_in = 1'b1;
                     end else begin
                        stack_req.wr_en   = 1'b1;
                        stack_req.wr_addr = cnt_ff[ADDR_W-1:0];
                        stack_req.wr_data = op_ff;
                        cnt_in            = cnt_ff + COUNT_W'(1);
                     end
                  end
                  KIND_CLOSE: begin
                     if (cnt_ff != '0) begin
                        cnt_in = cnt_m1;
                     end
                  end
                  default: begin
                     state_in = ST_MARK;
                  end
               endcase
            end
         end

         ST_MARK: begin
            if (beat_space) begin
               beat_valid    = 1'b1;
               beat.kind     = OUT_END;
               beat.overflow = ovf_ff;
               beat.last     = 1'b1;
               ovf_in        = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         pend_ff  <= pend_in;
      end
   end

   // token and pending operator payload
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      op_ff      <= op_in;
      pend_op_ff <= pend_op_in;
   end

endmodule

### src/infix_to_postfix_converter.sv
// infix to postfix converter top level: stream ports, sequencer, stack memory, result buffer
// an operand beat goes into the result buffer as it is taken; one token is taken per cycle
// for operands and opening braces while the buffer has space; operators, closing braces and
// end of expression read the stack top and then pop one entry at a time (end also emits the
// marker), paced by the registered stack read; results pass through a two-beat buffer
// reset clears stack count, overflow flag and buffer; the stack memory is not cleared
module infix_to_postfix_converter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // operand_value, operator_code, zero pad
   input  logic [itp_pkg::REQ_TDATA_W-1:0] req_tdata,
   // token_kind
   input  logic [itp_pkg::KIND_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_value, out_operator, overflow, zero pad
   output logic [itp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // out_kind
   output logic [itp_pkg::OKIND_W-1:0]     rsp_tuser,
   output logic                            rsp_tlast
);
   import itp_pkg::*;

   logic               beat_valid, beat_space;
   beat_type           beat, rsp_beat;
   stack_req_type      stack_req;
   logic [ENTRY_W-1:0] stack_top;

   // sequencer
   itp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (req_tvalid),
      .tok_ready  (req_tready),
      .tok_kind   (req_tuser),
      .tok_value  (req_tdata[VALUE_WIDTH-1:0]),
      .tok_oper   (req_tdata[REQ_FIELDS_W-1:VALUE_WIDTH]),
      .beat_valid (beat_valid),
      .beat       (beat),
      .beat_space (beat_space),
      .stack_req  (stack_req),
      .stack_top  (stack_top)
   );

   // operator stack
   itp_stack_ram #(
      .DEPTH  (STACK_DEPTH),
      .WIDTH  (ENTRY_W),
      .ADDR_W (ADDR_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stack_req.wr_en),
      .wr_addr (stack_req.wr_addr),
      .wr_data (stack_req.wr_data),
      .rd_en   (stack_req.rd_en),
      .rd_addr (stack_req.rd_addr),
      .rd_data (stack_top)
   );

   // result buffer
   itp_out_fifo u_out (
      .clock     (clock),
      .reset     (reset),
      .wr_valid  (beat_valid),
      .wr_beat   (beat),
      .has_space (beat_space),
      .rd_valid  (rsp_tvalid),
      .rd_ready  (rsp_tready),
      .rd_beat   (rsp_beat)
   );

   // pack the result beat
   assign rsp_tdata = RSP_TDATA_W'({rsp_beat.overflow, rsp_beat.oper, rsp_beat.value});
   assign rsp_tuser = rsp_beat.kind;
   assign rsp_tlast = rsp_beat.last;

endmodule
